### rtl/mqrb_pkg.sv
// types and constants shared by the multi-queue byte ring buffer
package mqrb_pkg;

  localparam int unsigned NumQueueRegs   = 4;
  localparam int unsigned DefNumQueues   = 4;
  localparam int unsigned DefMemBytes    = 256;
  localparam int unsigned DefMaxBurst    = 8;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_SHORT   = 2'd2,
    ST_NOMEM   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_INFO  = 2'd0,
    K_WRITE = 2'd1,
    K_READ  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  queue_id;
    logic [3:0]  byte_count;
    logic [63:0] push_data;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [7:0] fill_count;
    logic       last;
  } out_t;

  typedef struct packed {
    kind_e       kind;
    logic        advance;
    logic [1:0]  status;
    logic [7:0]  fill;
    logic [1:0]  qid;
    logic [3:0]  n;
    logic [7:0]  base;
    logic [7:0]  size;
    logic [63:0] data;
  } cmd_t;

endpackage

### rtl/mqrb_front.sv
// front end: size registers, fill counts and classification of each beat
module mqrb_front #(
  parameter int unsigned NUM_QUEUES      = 4,
  parameter int unsigned QUEUE_MEM_BYTES = 256,
  parameter int unsigned MAX_BURST       = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mqrb_pkg::in_t  in_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  output mqrb_pkg::cmd_t cmd_o
);
  import mqrb_pkg::*;

  logic [7:0] size_q [NumQueueRegs];
  logic [7:0] fill_q [NumQueueRegs];
  logic [9:0] base;
  logic [10:0] top;
  logic [3:0] n_sat;
  logic [8:0] sum;
  logic       qok;
  logic [7:0] fill_new;

  always_comb begin
    base = '0;
    for (int i = 0; i < NumQueueRegs; i++) begin
      if (i < int'(in_i.queue_id)) base = base + 10'(size_q[i]);
    end
    top   = 11'(base) + 11'(size_q[in_i.queue_id]);
    qok   = (32'(in_i.queue_id) < NUM_QUEUES) && (size_q[in_i.queue_id] != '0) &&
            (32'(top) < QUEUE_MEM_BYTES);
    n_sat = (32'(in_i.byte_count) > MAX_BURST) ? 4'(MAX_BURST) : in_i.byte_count;
    sum   = 9'(fill_q[in_i.queue_id]) + 9'(n_sat);

    cmd_o         = '0;
    cmd_o.kind    = K_INFO;
    cmd_o.qid     = in_i.queue_id;
    cmd_o.n       = n_sat;
    cmd_o.base    = base[7:0];
    cmd_o.size    = size_q[in_i.queue_id];
    cmd_o.data    = in_i.push_data;
    cmd_o.status  = ST_OK;
    cmd_o.fill    = fill_q[in_i.queue_id];
    cmd_o.advance = (in_i.op == OP_POP);
    fill_new      = fill_q[in_i.queue_id];

    if (in_i.op == OP_NONE) begin
      if (32'(in_i.queue_id) >= NUM_QUEUES) cmd_o.fill = '0;
    end else if (!qok) begin
      cmd_o.status = ST_NOMEM;
      cmd_o.fill   = '0;
    end else if (n_sat == '0) begin
      cmd_o.kind = K_INFO;
    end else if (in_i.op == OP_PUSH) begin
      cmd_o.kind = K_WRITE;
      if (sum >= 9'(size_q[in_i.queue_id])) begin
        fill_new     = size_q[in_i.queue_id];
        cmd_o.status = ST_OVERRUN;
      end else begin
        fill_new = sum[7:0];
      end
      cmd_o.fill = fill_new;
    end else if (fill_q[in_i.queue_id] < 8'(n_sat)) begin
      cmd_o.status = ST_SHORT;
    end else begin
      cmd_o.kind = K_READ;
      if (in_i.op == OP_POP) fill_new = fill_q[in_i.queue_id] - 8'(n_sat);
      cmd_o.fill = fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueueRegs; i++) begin
        size_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      size_q[cfg_idx_i] <= cfg_data_i;
      fill_q[cfg_idx_i] <= '0;
    end else if (accept_i) begin
      fill_q[in_i.queue_id] <= fill_new;
    end
  end

endmodule

### rtl/mqrb_back.sv
// back end: byte-serial memory access, ring indices and result queue
module mqrb_back #(
  parameter int unsigned QUEUE_MEM_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mqrb_pkg::cmd_t cmd_i,
  output logic           cmd_take_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic           pop_i,
  output logic           empty_o,
  output mqrb_pkg::out_t out_o
);
  import mqrb_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_MEM_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    logic       rd;
    logic [1:0] status;
    logic [7:0] fill;
    logic       last;
  } meta_t;

  state_e     state_q, state_d;
  cmd_t       cmd_q;
  logic [7:0] off_q, off_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] ridx_q [NumQueueRegs];
  logic [7:0] widx_q [NumQueueRegs];
  logic [7:0] mem_q [QUEUE_MEM_BYTES];
  logic [7:0] rdata_q;
  meta_t      meta_q, meta_d;
  logic       meta_v_q, meta_v_d;
  out_t       fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] fcnt_q;
  logic       room, step, done, we, re, deq;
  logic [7:0] off_nxt;
  logic [AW-1:0] addr;
  out_t       res;

  assign room    = (fcnt_q + 3'(meta_v_q)) < 3'd4;
  assign step    = (state_q == S_RUN) && room;
  assign off_nxt = (9'(off_q) + 9'd1 == 9'(cmd_q.size)) ? 8'd0 : off_q + 8'd1;
  assign addr    = AW'(cmd_q.base + off_q);
  assign done    = step && ((cmd_q.kind == K_INFO) || (cnt_q + 4'd1 == cmd_q.n));
  assign we      = step && (cmd_q.kind == K_WRITE);
  assign re      = step && (cmd_q.kind == K_READ);
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i;
  assign deq     = pop_i && !empty_o;
  assign empty_o = (fcnt_q == '0);
  assign out_o   = fifo_q[rp_q];

  always_comb begin
    state_d  = state_q;
    off_d    = off_q;
    cnt_d    = cnt_q;
    meta_v_d = 1'b0;
    meta_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_RUN;
          cnt_d   = '0;
          off_d   = (cmd_i.kind == K_READ) ? ridx_q[cmd_i.qid] : widx_q[cmd_i.qid];
        end
      end
      S_RUN: begin
        if (step) begin
          off_d = off_nxt;
          cnt_d = cnt_q + 4'd1;
          if (cmd_q.kind == K_READ || done) begin
            meta_v_d    = 1'b1;
            meta_d.rd   = (cmd_q.kind == K_READ);
            meta_d.status = cmd_q.status;
            meta_d.fill = cmd_q.fill;
            meta_d.last = done;
          end
          if (done) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= cmd_q.data[cnt_q[2:0]*8 +: 8];
    end else if (re) begin
      rdata_q <= mem_q[addr];
    end
    if (cmd_take_o) cmd_q <= cmd_i;
    off_q  <= off_d;
    cnt_q  <= cnt_d;
    meta_q <= meta_d;
  end

  always_comb begin
    res.status     = meta_q.status;
    res.data_byte  = meta_q.rd ? rdata_q : 8'd0;
    res.fill_count = meta_q.fill;
    res.last       = meta_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (meta_v_q) fifo_q[wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      meta_v_q <= 1'b0;
      wp_q     <= '0;
      rp_q     <= '0;
      fcnt_q   <= '0;
      for (int i = 0; i < NumQueueRegs; i++) begin
        ridx_q[i] <= '0;
        widx_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      meta_v_q <= meta_v_d;
      if (meta_v_q) wp_q <= wp_q + 2'd1;
      if (deq) rp_q <= rp_q + 2'd1;
      fcnt_q <= fcnt_q + 3'(meta_v_q) - 3'(deq);
      if (cfg_we_i) begin
        ridx_q[cfg_idx_i] <= '0;
        widx_q[cfg_idx_i] <= '0;
      end else if (done && cmd_q.kind == K_WRITE) begin
        widx_q[cmd_q.qid] <= off_nxt;
      end else if (done && cmd_q.kind == K_READ && cmd_q.advance) begin
        ridx_q[cmd_q.qid] <= off_nxt;
      end
    end
  end

endmodule

### rtl/multi_queue_byte_ring_buffer_unit.sv
// top level of the multi-queue byte ring buffer
// Up to four byte ring buffers share one single-port byte memory; queue i starts at
// the sum of the sizes of the lower queues. A push of n bytes writes n memory bytes and
// gives one result beat, a pop or peek of n bytes gives n result beats; rejected, short
// and empty accesses give one result beat. The single memory port moves one byte per
// cycle while the result queue has room, and the back end takes a new command only
// once the current one is done. A two-entry command queue sits between the classifying
// front end and the memory back end, and a four-entry result queue decouples the result
// side. Size registers are to be written only while the block is idle; the block itself
// does not enforce this. A write clears that queue's count and indices.
module multi_queue_byte_ring_buffer_unit #(
  parameter int unsigned NUM_QUEUES      = mqrb_pkg::DefNumQueues,
  parameter int unsigned QUEUE_MEM_BYTES = mqrb_pkg::DefMemBytes,
  parameter int unsigned MAX_BURST       = mqrb_pkg::DefMaxBurst
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  mqrb_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output mqrb_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);
  import mqrb_pkg::*;

  cmd_t       cmd_new;
  cmd_t       cq_q [2];
  logic       cq_wp_q, cq_rp_q;
  logic [1:0] cq_cnt_q;
  logic       accept, take;

  assign full   = (cq_cnt_q == 2'd2);
  assign accept = push && !full;

  mqrb_front #(
    .NUM_QUEUES(NUM_QUEUES), .QUEUE_MEM_BYTES(QUEUE_MEM_BYTES), .MAX_BURST(MAX_BURST)
  ) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .in_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cmd_o(cmd_new)
  );

  always_ff @(posedge clk_i) begin
    if (accept) cq_q[cq_wp_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wp_q  <= 1'b0;
      cq_rp_q  <= 1'b0;
      cq_cnt_q <= '0;
    end else begin
      if (accept) cq_wp_q <= !cq_wp_q;
      if (take) cq_rp_q <= !cq_rp_q;
      cq_cnt_q <= cq_cnt_q + 2'(accept) - 2'(take);
    end
  end

  mqrb_back #(.QUEUE_MEM_BYTES(QUEUE_MEM_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cq_cnt_q != '0), .cmd_i(cq_q[cq_rp_q]),
    .cmd_take_o(take), .cfg_we_i, .cfg_idx_i, .pop_i(pop), .empty_o(empty), .out_o
  );

`ifndef ASSERT_OFF
  a_cq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cq_cnt_q <= 2'd2)
    else $error("command queue overflow");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> cq_cnt_q != 2'd0)
    else $error("command taken from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !take) |=> cq_cnt_q == $past(cq_cnt_q) + 2'd1)
    else $error("command count lost a beat");
`endif

endmodule
